// ----- sv/pfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and arithmetic for the prime field ALU
// Payload structs, opcodes and modular add, subtract and halve helpers.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int LIMB_W     = 64;
    localparam int LIMB_COUNT = 4;
    localparam int W          = LIMB_W * LIMB_COUNT;
    localparam int CNT_W      = $clog2(W);
    localparam int IDX_W      = 8;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_SQR = 3'd3,
        OP_INV = 3'd4,
        OP_DIV = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [LIMB_W-1:0] a_limb0;
        logic [LIMB_W-1:0] a_limb1;
        logic [LIMB_W-1:0] a_limb2;
        logic [LIMB_W-1:0] a_limb3;
        logic [LIMB_W-1:0] b_limb0;
        logic [LIMB_W-1:0] b_limb1;
        logic [LIMB_W-1:0] b_limb2;
        logic [LIMB_W-1:0] b_limb3;
    } t_in;

    typedef struct packed {
        logic [LIMB_W-1:0] r_limb0;
        logic [LIMB_W-1:0] r_limb1;
        logic [LIMB_W-1:0] r_limb2;
        logic [LIMB_W-1:0] r_limb3;
        logic              result_is_zero;
    } t_out;

    // (x + y) mod m for x, y below m
    function automatic logic [W-1:0] f_mod_add(input logic [W-1:0] x,
                                               input logic [W-1:0] y,
                                               input logic [W-1:0] m);
        logic [W:0]   s;
        logic [W+1:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = {1'b0, s} - {2'b00, m};
        return d[W+1] ? s[W-1:0] : d[W-1:0];
    endfunction

    // (x - y) mod m for x, y below m
    function automatic logic [W-1:0] f_mod_sub(input logic [W-1:0] x,
                                               input logic [W-1:0] y,
                                               input logic [W-1:0] m);
        logic [W:0] d;
        d = {1'b0, x} - {1'b0, y};
        return d[W] ? (x + m - y) : d[W-1:0];
    endfunction

    // x / 2 mod m for odd m
    function automatic logic [W-1:0] f_mod_half(input logic [W-1:0] x,
                                                input logic [W-1:0] m);
        logic [W:0] s;
        s = x[0] ? ({1'b0, x} + {1'b0, m}) : {1'b0, x};
        return s[W:1];
    endfunction

endpackage

`default_nettype wire

// ----- sv/pfa_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_mul: bit-serial modular multiplier
// Scans y from the top bit, doubling and then conditionally adding x modulo m
// in separate phases for each bit. With x = 1 it reduces y modulo m.
// ----------------------------------------------------------------------------
module pfa_mul
    import pfa_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    input  wire logic [W-1:0] i_m,
    output logic              o_done,
    output logic [W-1:0]      o_prod
);

    logic             r_busy, n_busy;
    logic             r_phase, n_phase;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_x, n_x;
    logic [W-1:0]     r_y, n_y;

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        if (i_start && !r_busy) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_cnt   = CNT_W'(W - 1);
            n_acc   = '0;
            n_x     = i_x;
            n_y     = i_y;
        end else if (r_busy) begin
            if (!r_phase) begin
                n_acc   = f_mod_add(r_acc, r_acc, i_m);
                n_phase = 1'b1;
            end else begin
                n_acc   = f_mod_add(r_acc, r_y[W-1] ? r_x : '0, i_m);
                n_y     = {r_y[W-2:0], 1'b0};
                n_phase = 1'b0;
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- sv/pfa_inv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_inv: binary extended Euclidean inverse
// One shift or subtract step a cycle; gives zero for a zero operand,
// an even modulus or an operand without inverse.
// ----------------------------------------------------------------------------
module pfa_inv
    import pfa_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_m,
    output logic              o_done,
    output logic [W-1:0]      o_inv
);

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [W-1:0] r_u, n_u;
    logic [W-1:0] r_v, n_v;
    logic [W-1:0] r_s, n_s;
    logic [W-1:0] r_t, n_t;
    logic [W-1:0] r_res, n_res;
    logic [W:0]   w_uv;

    assign w_uv = {1'b0, r_u} - {1'b0, r_v};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_u    = r_u;
        n_v    = r_v;
        n_s    = r_s;
        n_t    = r_t;
        n_res  = r_res;
        if (i_start && !r_busy) begin
            if (!i_m[0] || i_x == '0) begin
                n_res  = '0;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_u    = i_x;
                n_v    = i_m;
                n_s    = W'(1);
                n_t    = '0;
            end
        end else if (r_busy) begin
            if (r_u == '0) begin
                n_res  = (r_v == W'(1)) ? r_t : '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_u[0]) begin
                n_u = r_u >> 1;
                n_s = f_mod_half(r_s, i_m);
            end else if (!r_v[0]) begin
                n_v = r_v >> 1;
                n_t = f_mod_half(r_t, i_m);
            end else if (!w_uv[W]) begin
                n_u = w_uv[W-1:0];
                n_s = f_mod_sub(r_s, r_t, i_m);
            end else begin
                n_v = r_v - r_u;
                n_t = f_mod_sub(r_t, r_s, i_m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_u   <= n_u;
        r_v   <= n_v;
        r_s   <= n_s;
        r_t   <= n_t;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_inv  = r_res;

endmodule

`default_nettype wire

// ----- sv/prime_field_alu_256.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prime_field_alu_256: 256-bit prime field arithmetic unit
// Add, subtract, multiply, square, inverse and divide modulo a programmed m.
// ----------------------------------------------------------------------------
// Usage: program modulus_limb0..3 through the write port (index 0..3) while
// idle. Present an item on i_in_valid/i_in_data; a transfer happens when
// o_in_stall is low. One item is worked at a time; o_in_stall stays high from
// the transfer until its result is loaded into the output register.
// Sequence: both operands are first reduced modulo m bit-serially. Add and
// subtract then pass through S_FIN and S_WAIT into the output register;
// multiply and square run one more multiply, inverse runs the
// shift/subtract steps of the inverse unit, divide an inverse plus a multiply.
// Rate is set by the bit-serial multiplier and the one-step-per-cycle
// inverse unit. A zero modulus gives zero without the operand reductions.
// The result waits in the output register while i_out_stall is high; a new
// item can be accepted meanwhile. Reset clears the modulus and empties the
// pipeline.
// ----------------------------------------------------------------------------
module prime_field_alu_256
    import pfa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMB_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_REDA = 7'b0000010,
        S_REDB = 7'b0000100,
        S_INV  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    logic [2:0]   r_op, n_op;
    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_res, n_res;
    logic [W-1:0] r_mx, n_mx;
    logic [W-1:0] r_my, n_my;
    logic [W-1:0] r_ix, n_ix;
    logic         r_mul_go, n_mul_go;
    logic         r_inv_go, n_inv_go;
    logic         r_out_valid, n_out_valid;
    t_out         r_out, n_out;
    logic [W-1:0] r_mod;

    logic         w_mul_done, w_inv_done;
    logic [W-1:0] w_prod, w_inv;
    logic         w_in_xfer;

    assign w_in_xfer = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
        end else if (i_cfg_we && i_cfg_index < IDX_W'(LIMB_COUNT)) begin
            r_mod[i_cfg_index[1:0]*LIMB_W +: LIMB_W] <= i_cfg_data;
        end
    end

    pfa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_m     (r_mod),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pfa_inv u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_inv_go),
        .i_x     (r_ix),
        .i_m     (r_mod),
        .o_done  (w_inv_done),
        .o_inv   (w_inv)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_res       = r_res;
        n_mx        = r_mx;
        n_my        = r_my;
        n_ix        = r_ix;
        n_mul_go    = 1'b0;
        n_inv_go    = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op = i_in_data.opcode;
                    n_a  = {i_in_data.a_limb3, i_in_data.a_limb2,
                            i_in_data.a_limb1, i_in_data.a_limb0};
                    n_b  = {i_in_data.b_limb3, i_in_data.b_limb2,
                            i_in_data.b_limb1, i_in_data.b_limb0};
                    if (r_mod == '0) begin
                        n_res   = '0;
                        n_state = S_FIN;
                    end else begin
                        n_mul_go = 1'b1;
                        n_mx     = W'(1);
                        n_my     = n_a;
                        n_state  = S_REDA;
                    end
                end
            end
            S_REDA: begin
                if (w_mul_done) begin
                    n_a      = w_prod;
                    n_mul_go = 1'b1;
                    n_mx     = W'(1);
                    n_my     = r_b;
                    n_state  = S_REDB;
                end
            end
            S_REDB: begin
                if (w_mul_done) begin
                    n_b = w_prod;
                    unique case (r_op)
                        OP_ADD: begin
                            n_res   = f_mod_add(r_a, w_prod, r_mod);
                            n_state = S_FIN;
                        end
                        OP_SUB: begin
                            n_res   = f_mod_sub(r_a, w_prod, r_mod);
                            n_state = S_FIN;
                        end
                        OP_MUL: begin
                            n_mul_go = 1'b1;
                            n_mx     = r_a;
                            n_my     = w_prod;
                            n_state  = S_MUL;
                        end
                        OP_SQR: begin
                            n_mul_go = 1'b1;
                            n_mx     = r_a;
                            n_my     = r_a;
                            n_state  = S_MUL;
                        end
                        OP_INV: begin
                            n_inv_go = 1'b1;
                            n_ix     = r_a;
                            n_state  = S_INV;
                        end
                        OP_DIV: begin
                            n_inv_go = 1'b1;
                            n_ix     = w_prod;
                            n_state  = S_INV;
                        end
                        default: begin
                            n_res   = '0;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_INV: begin
                if (w_inv_done) begin
                    if (r_op == OP_DIV) begin
                        n_mul_go = 1'b1;
                        n_mx     = r_a;
                        n_my     = w_inv;
                        n_state  = S_MUL;
                    end else begin
                        n_res   = w_inv;
                        n_state = S_FIN;
                    end
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_res   = w_prod;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.r_limb0        = r_res[0*LIMB_W +: LIMB_W];
                    n_out.r_limb1        = r_res[1*LIMB_W +: LIMB_W];
                    n_out.r_limb2        = r_res[2*LIMB_W +: LIMB_W];
                    n_out.r_limb3        = r_res[3*LIMB_W +: LIMB_W];
                    n_out.result_is_zero = (r_res == '0);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_go    <= 1'b0;
            r_inv_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_go    <= n_mul_go;
            r_inv_go    <= n_inv_go;
            r_out_valid <= n_out_valid;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_res <= n_res;
        r_mx  <= n_mx;
        r_my  <= n_my;
        r_ix  <= n_ix;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_xfer_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state != S_IDLE))
        else $error("state did not advance after input transfer");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_REDA || r_state == S_REDB || r_state == S_MUL))
        else $error("multiplier finished outside a waiting state");

    a_inv_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inv_done |-> (r_state == S_INV))
        else $error("inverse finished outside its waiting state");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.result_is_zero ==
            (o_out_data.r_limb0 == '0 && o_out_data.r_limb1 == '0 &&
             o_out_data.r_limb2 == '0 && o_out_data.r_limb3 == '0)))
        else $error("zero flag disagrees with result");

endmodule

`default_nettype wire
